/* rtl/qtg_pkg.sv */
// Shared types and constants for the quintic trajectory generator.
// No dependencies; qtg_div, the generator and the testbench import this package.
package qtg_pkg;

  localparam int AXES   = 3;
  localparam int DUR_W  = 16;   // tick counters
  localparam int U_FRAC = 20;   // u is unsigned Q0.20
  localparam int CFG_W  = 24;   // v0 and a0, signed Q8.16
  localparam int COEF_W = 30;   // blend coefficients, Q.17
  localparam int HP_W   = 32;   // Horner accumulator
  localparam int S_W    = 24;   // blend s, signed Q4.20

  localparam logic [DUR_W-1:0] RESET_DURATION = 16'd1000;
  localparam logic signed [CFG_W-1:0] RESET_VEL = 24'sd52429;
  localparam logic signed [CFG_W-1:0] RESET_ACC = 24'sd301466;

  // 10, 15 and 6 in Q.17
  localparam logic signed [COEF_W-1:0] K10 = 30'sd1310720;
  localparam logic signed [COEF_W-1:0] K15 = 30'sd1966080;
  localparam logic signed [COEF_W-1:0] K6  = 30'sd786432;

  localparam logic signed [HP_W+2:0] S_MAX = 35'sd8388607;
  localparam logic signed [HP_W+2:0] S_MIN = -35'sd8388608;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic REG_START_VEL = 1'b0;
  localparam logic REG_START_ACC = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_HORN,
    ST_LERP,
    ST_OUT
  } state_e;

endpackage

/* rtl/qtg_div.sv */
// Bit-serial restoring divider: quotient = floor(num * 2^20 / den), num < den.
// Depends on qtg_pkg.
module qtg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [qtg_pkg::DUR_W-1:0]    num_i,
  input  logic [qtg_pkg::DUR_W-1:0]    den_i,
  output logic                         done_o,
  output logic [qtg_pkg::U_FRAC-1:0]   quo_o
);
  import qtg_pkg::*;

  localparam int CW = $clog2(U_FRAC + 1);

  logic [DUR_W-1:0]  rem_q;
  logic [DUR_W-1:0]  den_q;
  logic [U_FRAC-1:0] quo_q;
  logic [CW-1:0]     cnt_q;
  logic              done_q;
  logic [DUR_W:0]    rem2;
  logic              ge;

  always_comb begin
    rem2 = {rem_q, 1'b0};
    ge   = rem2 >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(U_FRAC);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? DUR_W'(rem2 - {1'b0, den_q}) : rem2[DUR_W-1:0];
      quo_q <= {quo_q[U_FRAC-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/qtg_smul.sv */
// Bit-serial shift-add multiplier: prod = floor(a * b / 2^NB), b unsigned.
// One multiplier bit per cycle; no package dependencies.
module qtg_smul #(
  parameter int AW = 32,
  parameter int NB = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] a_i,
  input  logic [NB-1:0]        b_i,
  output logic                 done_o,
  output logic signed [AW-1:0] prod_o
);
  localparam int CW = $clog2(NB + 1);

  logic signed [AW-1:0] a_q;
  logic signed [AW-1:0] acc_q;
  logic [NB-1:0]        b_q;
  logic [CW-1:0]        cnt_q;
  logic                 done_q;
  logic signed [AW:0]   sum;

  // floor((acc + bit*a) / 2) each step keeps the overall floor exact
  always_comb begin
    sum = (AW+1)'(acc_q) + (b_q[0] ? (AW+1)'(a_q) : (AW+1)'(0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(NB);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= sum[AW:1];
      b_q   <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* rtl/quintic_trajectory_generator.sv */
// Three-axis quintic trajectory generator. A start transaction (opcode 0) loads positions,
// goals and duration; a tick while idle gives nothing. The final tick loads the goals into
// the result register, from which they go to the output register with done_res_o set, and
// the next transaction is accepted once the output register has been loaded. An interpolated
// tick runs the bit-serial divide of u, then five passes through one bit-serial multiplier for
// the Horner blend, then the per-axis bit-serial lerp multipliers, which run in parallel, and
// then loads the output register; the input is held off until that load. A stalled output
// only holds the input off once a second result is ready. The user must write configuration
// only while no transaction is in flight; the block itself does not enforce this.
module quintic_trajectory_generator #(
  parameter int POS_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [qtg_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic signed [POS_WIDTH-1:0]        axis0_now_i,
  input  logic signed [POS_WIDTH-1:0]        axis1_now_i,
  input  logic signed [POS_WIDTH-1:0]        axis2_now_i,
  input  logic signed [POS_WIDTH-1:0]        axis0_goal_i,
  input  logic signed [POS_WIDTH-1:0]        axis1_goal_i,
  input  logic signed [POS_WIDTH-1:0]        axis2_goal_i,
  input  logic [qtg_pkg::DUR_W-1:0]          move_ticks_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [POS_WIDTH-1:0]        axis0_cmd_o,
  output logic signed [POS_WIDTH-1:0]        axis1_cmd_o,
  output logic signed [POS_WIDTH-1:0]        axis2_cmd_o,
  output logic                               done_res_o
);
  import qtg_pkg::*;

  localparam int PW    = POS_WIDTH;
  localparam int DW    = PW + 1;   // goal - start
  localparam int SUM_W = PW + 6;
  localparam logic signed [SUM_W-1:0] PMAX = (SUM_W'(1) <<< (PW - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] PMIN = -PMAX - SUM_W'(1);

  state_e state_q, state_d;

  logic signed [CFG_W-1:0] vel_q, acc_q;
  logic signed [PW-1:0]    start_q [AXES];
  logic signed [PW-1:0]    goal_q  [AXES];
  logic signed [PW-1:0]    now_in  [AXES];
  logic signed [PW-1:0]    goal_in [AXES];
  logic [DUR_W-1:0]        elapsed_q, dur_q;
  logic                    running_q;

  logic signed [HP_W-1:0]  p_q;
  logic [2:0]              hstep_q;
  logic                    hgo_q, lgo_q;
  logic signed [S_W-1:0]   s_q;

  logic signed [PW-1:0]    res_q [AXES];
  logic                    res_done_q;
  logic signed [PW-1:0]    cmd_q [AXES];
  logic                    done_q, out_valid_q;

  logic in_acc, is_tick, is_final, div_go, out_load;
  logic div_done, hm_done;
  logic [U_FRAC-1:0]      u;
  logic signed [HP_W-1:0] hm_prod;

  logic signed [COEF_W-1:0] v, a, c1, c2, c3, c4, c5, csel;
  logic signed [HP_W-1:0]   p_next;
  logic signed [HP_W+2:0]   p8;
  logic signed [S_W-1:0]    s_next;

  logic signed [DW-1:0]     d      [AXES];
  logic signed [DW-1:0]     l_prod [AXES];
  logic                     l_done [AXES];
  logic signed [SUM_W-1:0]  l_sum  [AXES];
  logic signed [PW-1:0]     l_res  [AXES];
  logic signed [3:0]        s_hi;

  assign now_in[0]  = axis0_now_i;
  assign now_in[1]  = axis1_now_i;
  assign now_in[2]  = axis2_now_i;
  assign goal_in[0] = axis0_goal_i;
  assign goal_in[1] = axis1_goal_i;
  assign goal_in[2] = axis2_goal_i;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign is_tick    = (opcode_i == OP_TICK);
  assign is_final   = ({1'b0, elapsed_q} + 17'd1) >= {1'b0, dur_q};
  assign div_go     = in_acc && is_tick && running_q && !is_final;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // blend coefficients in Q.17 from v0, a0 (Q8.16)
  always_comb begin
    v  = COEF_W'(vel_q);
    a  = COEF_W'(acc_q);
    c1 = v <<< 1;
    c2 = a;
    c3 = K10 - (v <<< 3) - (v <<< 2) - (a <<< 1) - a;
    c4 = -K15 + (v <<< 4) + (a <<< 1) + a;
    c5 = K6 - (v <<< 2) - (v <<< 1) - a;
    case (hstep_q)
      3'd0:    csel = c4;
      3'd1:    csel = c3;
      3'd2:    csel = c2;
      3'd3:    csel = c1;
      default: csel = '0;
    endcase
    p_next = hm_prod + HP_W'(csel);
    p8     = (HP_W+3)'(p_next) <<< 3;
    if (p8 > S_MAX)      s_next = S_W'(S_MAX);
    else if (p8 < S_MIN) s_next = S_W'(S_MIN);
    else                 s_next = S_W'(p8);
  end

  qtg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (elapsed_q),
    .den_i   (dur_q),
    .done_o  (div_done),
    .quo_o   (u)
  );

  qtg_smul #(.AW(HP_W), .NB(U_FRAC)) u_horn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hgo_q),
    .a_i     (p_q),
    .b_i     (u),
    .done_o  (hm_done),
    .prod_o  (hm_prod)
  );

  assign s_hi = s_q[S_W-1:U_FRAC];

  for (genvar k = 0; k < AXES; k++) begin : g_lane
    assign d[k] = DW'(goal_q[k]) - DW'(start_q[k]);

    qtg_smul #(.AW(DW), .NB(U_FRAC)) u_lerp (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (lgo_q),
      .a_i     (d[k]),
      .b_i     (s_q[U_FRAC-1:0]),
      .done_o  (l_done[k]),
      .prod_o  (l_prod[k])
    );

    // start + floor(d * s / 2^20), the upper signed digit of s added exactly
    always_comb begin
      l_sum[k] = SUM_W'(start_q[k]) + SUM_W'(l_prod[k]) + SUM_W'(SUM_W'(d[k]) * SUM_W'(s_hi));
      if (l_sum[k] > PMAX)      l_res[k] = PW'(PMAX);
      else if (l_sum[k] < PMIN) l_res[k] = PW'(PMIN);
      else                      l_res[k] = PW'(l_sum[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_tick && running_q) state_d = is_final ? ST_OUT : ST_DIV;
      end
      ST_DIV:  if (div_done) state_d = ST_HORN;
      ST_HORN: if (hm_done && hstep_q == 3'd4) state_d = ST_LERP;
      ST_LERP: if (l_done[0]) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q       <= RESET_VEL;
      acc_q       <= RESET_ACC;
      elapsed_q   <= '0;
      dur_q       <= RESET_DURATION;
      running_q   <= 1'b0;
      hgo_q       <= 1'b0;
      lgo_q       <= 1'b0;
      hstep_q     <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < AXES; k++) begin
        start_q[k] <= '0;
        goal_q[k]  <= '0;
      end
    end else begin
      hgo_q <= 1'b0;
      lgo_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_START_VEL) vel_q <= cfg_wdata_i;
        else                              acc_q <= cfg_wdata_i;
      end
      if (in_acc && !is_tick) begin
        for (int k = 0; k < AXES; k++) begin
          start_q[k] <= now_in[k];
          goal_q[k]  <= goal_in[k];
        end
        dur_q     <= move_ticks_i;
        elapsed_q <= '0;
        running_q <= 1'b1;
      end else if (in_acc && running_q) begin
        if (is_final) begin
          elapsed_q <= dur_q;
          running_q <= 1'b0;
        end else begin
          elapsed_q <= elapsed_q + DUR_W'(1);
        end
      end
      if (state_q == ST_DIV && div_done) begin
        hstep_q <= '0;
        hgo_q   <= 1'b1;
      end
      if (state_q == ST_HORN && hm_done) begin
        if (hstep_q == 3'd4) lgo_q <= 1'b1;
        else begin
          hstep_q <= hstep_q + 3'd1;
          hgo_q   <= 1'b1;
        end
      end
      if (out_load)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && div_done) p_q <= HP_W'(c5);
    if (state_q == ST_HORN && hm_done) begin
      p_q <= p_next;
      s_q <= s_next;
    end
    if (in_acc && is_tick && running_q && is_final) begin
      for (int k = 0; k < AXES; k++) res_q[k] <= goal_q[k];
      res_done_q <= 1'b1;
    end
    if (state_q == ST_LERP && l_done[0]) begin
      for (int k = 0; k < AXES; k++) res_q[k] <= l_res[k];
      res_done_q <= 1'b0;
    end
    if (out_load) begin
      for (int k = 0; k < AXES; k++) cmd_q[k] <= res_q[k];
      done_q <= res_done_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign axis0_cmd_o = cmd_q[0];
  assign axis1_cmd_o = cmd_q[1];
  assign axis2_cmd_o = cmd_q[2];
  assign done_res_o  = done_q;

endmodule

/* test/tb_top.sv */
// Testbench for quintic_trajectory_generator: random and directed moves and ticks,
// checked against an in-bench fixed-point model of the quintic blend.
// Depends on qtg_pkg and the generator RTL.
`timescale 1ns / 100ps

module tb_top;
  import qtg_pkg::*;

  typedef struct {
    logic                opcode;
    logic signed [31:0]  now_pos [AXES];
    logic signed [31:0]  goal_pos [AXES];
    logic [DUR_W-1:0]    ticks;
  } move_item_t;

  typedef struct {
    logic signed [31:0] cmd [AXES];
    logic               done;
  } cmd_item_t;

  localparam int WATCHDOG = 200000;

  logic clk, rst_n;
  logic cfg_we, cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_valid, in_stall, opcode;
  logic signed [31:0] now_p [AXES];
  logic signed [31:0] goal_p [AXES];
  logic [DUR_W-1:0] move_ticks;
  logic out_valid, out_stall, done_res;
  logic signed [31:0] cmd_p [AXES];

  // stall as seen at the last rising edge, so the driver acts on the accepted state
  logic in_stall_q;

  quintic_trajectory_generator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .opcode_i(opcode),
    .axis0_now_i(now_p[0]), .axis1_now_i(now_p[1]), .axis2_now_i(now_p[2]),
    .axis0_goal_i(goal_p[0]), .axis1_goal_i(goal_p[1]), .axis2_goal_i(goal_p[2]),
    .move_ticks_i(move_ticks),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .axis0_cmd_o(cmd_p[0]), .axis1_cmd_o(cmd_p[1]), .axis2_cmd_o(cmd_p[2]),
    .done_res_o(done_res)
  );

  // predictor state
  longint m_vel, m_acc;
  longint m_start [AXES];
  longint m_goal [AXES];
  int unsigned m_elapsed, m_duration;
  bit m_running;

  move_item_t pending_moves[$];
  cmd_item_t  expected_cmds[$];
  int send_idle_pct, recv_stall_pct;
  int errors, quiet_cycles;

  function automatic longint floor_div2(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint sat_range(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint quintic_blend(int unsigned el, int unsigned dur);
    longint u, p, c1, c2, c3, c4, c5;
    c1 = 2 * m_vel;
    c2 = m_acc;
    c3 = (longint'(10) << 17) - 12 * m_vel - 3 * m_acc;
    c4 = -(longint'(15) << 17) + 16 * m_vel + 3 * m_acc;
    c5 = (longint'(6) << 17) - 6 * m_vel - m_acc;
    if (dur == 0 || el >= dur) u = longint'(1) << U_FRAC;
    else u = (longint'(el) << U_FRAC) / longint'(dur);
    p = c5;
    p = floor_div2(p * u, U_FRAC) + c4;
    p = floor_div2(p * u, U_FRAC) + c3;
    p = floor_div2(p * u, U_FRAC) + c2;
    p = floor_div2(p * u, U_FRAC) + c1;
    p = floor_div2(p * u, U_FRAC);
    return sat_range(p * 8, -longint'(8388608), longint'(8388607));
  endfunction

  function automatic longint blend_axis(longint a, longint b, longint s);
    longint d, sh, sl, t;
    d = b - a;
    sh = floor_div2(s, 12);
    sl = s - sh * 4096;
    t = d * sh + floor_div2(d * sl, 12);
    return sat_range(a + floor_div2(t, 8), -(longint'(1) <<< 31),
                     (longint'(1) <<< 31) - 1);
  endfunction

  function automatic void predict_move(move_item_t it);
    cmd_item_t r;
    longint s;
    if (it.opcode == OP_START) begin
      for (int i = 0; i < AXES; i++) begin
        m_start[i] = it.now_pos[i];
        m_goal[i] = it.goal_pos[i];
      end
      m_duration = it.ticks;
      m_elapsed = 0;
      m_running = 1;
      return;
    end
    if (!m_running) return;
    if (m_elapsed + 1 >= m_duration) begin
      for (int i = 0; i < AXES; i++) r.cmd[i] = m_goal[i][31:0];
      r.done = 1;
      m_elapsed = m_duration;
      m_running = 0;
    end else begin
      s = quintic_blend(m_elapsed, m_duration);
      for (int i = 0; i < AXES; i++) r.cmd[i] = 32'(blend_axis(m_start[i], m_goal[i], s));
      r.done = 0;
      m_elapsed = (m_elapsed + 1) & 16'hFFFF;
    end
    expected_cmds.push_back(r);
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // driver
  always @(negedge clk) begin
    move_item_t it;
    bit send;
    send = (!in_valid || !in_stall_q) && pending_moves.size() > 0 && rst_n &&
           ($urandom_range(99) >= send_idle_pct);
    if (send) begin
      it = pending_moves.pop_front();
      in_valid <= 1;
      opcode <= it.opcode;
      for (int i = 0; i < AXES; i++) begin
        now_p[i] <= it.now_pos[i];
        goal_p[i] <= it.goal_pos[i];
      end
      move_ticks <= it.ticks;
      predict_move(it);
    end else if (in_valid && !in_stall_q) begin
      in_valid <= 0;
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    in_stall_q <= in_stall;
  end

  // monitor
  always @(posedge clk) begin
    cmd_item_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected transaction cmd %h %h %h done %b", $time,
                   cmd_p[0], cmd_p[1], cmd_p[2], done_res);
          errors++;
        end else begin
          e = expected_cmds.pop_front();
          for (int i = 0; i < AXES; i++)
            if (cmd_p[i] !== e.cmd[i]) begin
              $display("%0t: axis%0d cmd expected %h actual %h", $time, i, e.cmd[i],
                       cmd_p[i]);
              errors++;
            end
          if (done_res !== e.done) begin
            $display("%0t: done expected %b actual %b", $time, e.done, done_res);
            errors++;
          end
        end
      end
      if (quiet_cycles > WATCHDOG) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(2000))) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_move(logic op, int unsigned ticks, bit extreme);
    move_item_t it;
    it.opcode = op;
    for (int i = 0; i < AXES; i++) begin
      it.now_pos[i] = rand_pos();
      it.goal_pos[i] = rand_pos();
      if (extreme) begin
        it.now_pos[i] = (i == 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
        it.goal_pos[i] = (i == 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      end
    end
    it.ticks = DUR_W'(ticks);
    pending_moves.push_back(it);
  endfunction

  task automatic drain();
    while (pending_moves.size() > 0 || in_valid || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_START_VEL) m_vel = longint'($signed(val));
    else m_acc = longint'($signed(val));
  endtask

  // a start followed by random ticks with occasional restarts, mostly small durations
  task automatic queue_run(int n);
    int d;
    d = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(12);
    queue_move(OP_START, d, 0);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(30) == 0) queue_move(OP_START, $urandom_range(8), 0);
      else queue_move(OP_TICK, $urandom, 0);
    end
  endtask

  initial begin
    int phase_pct [4][2];
    phase_pct = '{'{0, 0}, '{59, 0}, '{0, 59}, '{12, 12}};
    rst_n = 0; cfg_we = 0; cfg_index = REG_START_VEL; cfg_wdata = 0;
    in_valid = 0; opcode = OP_TICK; move_ticks = 0; out_stall = 0;
    for (int i = 0; i < AXES; i++) begin now_p[i] = 0; goal_p[i] = 0; end
    in_stall_q = 0; errors = 0; quiet_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    m_vel = 52429; m_acc = 301466; m_elapsed = 0; m_duration = 1000; m_running = 0;
    for (int i = 0; i < AXES; i++) begin m_start[i] = 0; m_goal[i] = 0; end
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // directed: idle tick, zero duration, full-range swings, restart mid-run
    queue_move(OP_TICK, 0, 0);
    queue_move(OP_START, 0, 1);
    queue_move(OP_TICK, 0, 0);
    queue_move(OP_TICK, 0, 0);
    queue_move(OP_START, 5, 1);
    repeat (3) queue_move(OP_TICK, 65535, 0);
    queue_move(OP_START, 65535, 1);
    repeat (3) queue_move(OP_TICK, 0, 0);
    queue_move(OP_START, 1, 0);
    queue_move(OP_TICK, 0, 0);
    queue_move(OP_START, 4, 0);
    repeat (5) queue_move(OP_TICK, 0, 0);
    drain();

    for (int c = 0; c < 6; c++) begin
      case (c)
        0: begin write_cfg(REG_START_VEL, 24'h7FFFFF); write_cfg(REG_START_ACC, 24'h800000); end
        1: begin write_cfg(REG_START_VEL, 24'h800000); write_cfg(REG_START_ACC, 24'h7FFFFF); end
        2: begin write_cfg(REG_START_VEL, 0); write_cfg(REG_START_ACC, 0); end
        3: begin
          write_cfg(REG_START_VEL, CFG_W'($urandom));
          write_cfg(REG_START_ACC, CFG_W'($urandom));
        end
        4: begin write_cfg(REG_START_VEL, 24'd52429); write_cfg(REG_START_ACC, 24'd301466); end
        default: begin write_cfg(REG_START_VEL, 24'hFFFFFF); write_cfg(REG_START_ACC, 24'h555555); end
      endcase
      for (int p = 0; p < 4; p++) begin
        send_idle_pct = phase_pct[p][0];
        recv_stall_pct = phase_pct[p][1];
        for (int r = 0; r < 4; r++) queue_run($urandom_range(5, 14));
        if (p == 1) drain();
      end
      drain();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    drain();

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
